// ===== rtl/core/wgmcp_pkg.sv =====
// Shared types and constants for the wrapped grid minimum cost path block.
// Used by every module under rtl/core; depends on nothing.
package wgmcp_pkg;

  // Field widths fixed by the interface.
  localparam int COST_W      = 16;
  localparam int PATH_W      = 22;
  localparam int ROWS_CFG_W  = 4;
  localparam int COLS_CFG_W  = 7;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 3;

  // Configuration register indexes (byte address is four times the index).
  localparam logic REG_ROWS_USED = 1'b0;
  localparam logic REG_COLS_USED = 1'b1;

  localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = 4'd5;
  localparam logic [COLS_CFG_W-1:0] COLS_RESET = 7'd6;

  // Saturated path cost.
  localparam logic [PATH_W-1:0] PATH_MAX = '1;

  // One classified cell, handed from the front end to the back end.
  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic              first_col;  // first column: path cost is the cell cost
    logic              last_col;   // last column: feeds the final minimum
    logic              row_first;  // top row of a column
    logic              row_last;   // bottom row of a column
    logic              grid_end;   // last cell of the grid
  } cell_cmd_t;

endpackage

// ===== rtl/core/wgmcp_front.sv =====
// Front end: accepts cell costs and tags each with its position in the grid.
// Depends on wgmcp_pkg.
module wgmcp_front
  import wgmcp_pkg::*;
#(
  parameter int ROW_W = 3,
  parameter int COL_W = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              restart,
  input  logic [ROW_W-1:0]  rows_m1,
  input  logic [COL_W-1:0]  cols_m1,
  input  logic              in_fire,
  input  logic [COST_W-1:0] in_cost,
  output cell_cmd_t         cmd
);

  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic             row_last;
  logic             col_last;

  // Classify the incoming cell from the position counters.
  assign row_last = (row_r == rows_m1);
  assign col_last = (col_r == cols_m1);

  always_comb begin
    cmd.cost      = in_cost;
    cmd.first_col = (col_r == '0);
    cmd.last_col  = col_last;
    cmd.row_first = (row_r == '0);
    cmd.row_last  = row_last;
    cmd.grid_end  = row_last && col_last;
  end

  // Walk rows within a column, then columns; a configuration write restarts.
  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (restart) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (in_fire) begin
      if (row_last) begin
        row_nxt = '0;
        col_nxt = col_last ? '0 : col_r + 1'b1;
      end else begin
        row_nxt = row_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

endmodule

// ===== rtl/core/wgmcp_queue.sv =====
// Two-entry queue of classified cells between the front and back ends.
// Depends on wgmcp_pkg.
module wgmcp_queue
  import wgmcp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_en,
  input  cell_cmd_t wr_data,
  output logic      full,
  input  logic      rd_en,
  output logic      rd_valid,
  output cell_cmd_t rd_data
);

  cell_cmd_t  slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full     = (count_r == 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign rd_data  = slot_r[rd_ptr_r];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = wr_en ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = rd_en ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Payload storage needs no reset.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== rtl/core/wgmcp_back.sv =====
// Back end: computes path costs from a history line of earlier results and
// keeps the final minimum and the result register. Depends on wgmcp_pkg.
module wgmcp_back
  import wgmcp_pkg::*;
#(
  parameter int MAX_ROWS = 8,
  parameter int ROW_W    = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [ROW_W-1:0]  rows_m1,
  input  logic              cmd_valid,
  input  cell_cmd_t         cmd,
  output logic              cmd_pop,
  output logic              out_valid,
  output logic [PATH_W-1:0] out_cost,
  input  logic              out_pop
);

  localparam int HIST_D = (MAX_ROWS < 2) ? 2 : MAX_ROWS;

  // The history line holds the last path costs in arrival order. The newest
  // enters at the tap that is rows_m1 from the head, so the head is always
  // the same row of the previous column and the next tap the row below.
  logic [PATH_W-1:0] hist_r [HIST_D];
  logic [PATH_W-1:0] hist_nxt [HIST_D];
  logic [PATH_W-1:0] hist_old_r;   // one step older than the head: row above
  logic [PATH_W-1:0] last_path_r;  // the cell just computed
  logic [PATH_W-1:0] row0_cur_r;   // top row of the current column
  logic [PATH_W-1:0] row0_prev_r;  // top row of the previous column
  logic [PATH_W-1:0] best_r, best_nxt;
  logic              out_valid_r;
  logic [PATH_W-1:0] out_cost_r;

  logic [PATH_W-1:0] up_cost, mid_cost, dn_cost, min_ud, min3;
  logic [PATH_W:0]   sum;
  logic [PATH_W-1:0] path;
  logic              fire;

  // A cell leaves the queue unless it ends a grid and the result slot is busy.
  assign fire    = cmd_valid && (!cmd.grid_end || !out_valid_r || out_pop);
  assign cmd_pop = fire;

  // Neighbor selection with row wrap; a single row sees only itself.
  always_comb begin
    up_cost  = cmd.row_first ? last_path_r : hist_old_r;
    mid_cost = hist_r[0];
    if (cmd.row_last) begin
      dn_cost = cmd.row_first ? last_path_r : row0_prev_r;
    end else begin
      dn_cost = hist_r[1];
    end
  end

  // Three-way minimum, add and saturate.
  always_comb begin
    min_ud = (up_cost < mid_cost) ? up_cost : mid_cost;
    min3   = (min_ud < dn_cost) ? min_ud : dn_cost;
    sum    = {1'b0, min3} + {{(PATH_W + 1 - COST_W){1'b0}}, cmd.cost};
    if (cmd.first_col) begin
      path = {{(PATH_W - COST_W){1'b0}}, cmd.cost};
    end else begin
      path = sum[PATH_W] ? PATH_MAX : sum[PATH_W-1:0];
    end
  end

  // Running minimum over the last column.
  always_comb begin
    best_nxt = best_r;
    if (cmd.last_col && (cmd.row_first || path < best_r)) begin
      best_nxt = path;
    end
  end

  // History line shift.
  always_comb begin
    for (int k = 0; k < HIST_D - 1; k++) begin
      hist_nxt[k] = (ROW_W'(k) == rows_m1) ? path : hist_r[k+1];
    end
    hist_nxt[HIST_D-1] = (ROW_W'(HIST_D - 1) == rows_m1) ? path : hist_r[HIST_D-1];
  end

  // Datapath registers, updated per processed cell.
  always_ff @(posedge clk) begin
    if (fire) begin
      hist_r      <= hist_nxt;
      hist_old_r  <= hist_r[0];
      last_path_r <= path;
      best_r      <= best_nxt;
      if (cmd.row_first) begin
        row0_prev_r <= row0_cur_r;
        row0_cur_r  <= path;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && cmd.grid_end) begin
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && cmd.grid_end) begin
      out_cost_r <= best_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_cost  = out_cost_r;

`ifndef SYNTH
  // A finished grid always lands in the result register.
  a_grid_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire && cmd.grid_end |=> out_valid_r && (out_cost_r == $past(best_nxt)))
    else $error("grid result not captured");

  // A pending result is never overwritten before it is taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_pop |-> !(fire && cmd.grid_end))
    else $error("pending result overwritten");

  // A first-column cell carries its own cost as path cost.
  a_first_col_path: assert property (@(posedge clk) disable iff (!rst_n)
    fire && cmd.first_col |=>
      last_path_r == {{(PATH_W - COST_W){1'b0}}, $past(cmd.cost)})
    else $error("first column path cost wrong");

  // History advances only when a cell is processed.
  a_hist_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(last_path_r) && $stable(hist_old_r))
    else $error("history changed without a cell");
`endif

endmodule

// ===== rtl/core/wrapped_grid_min_cost_path_top.sv =====
// Top level of the wrapped grid minimum cost path block: configuration
// registers, front end, cell queue and back end. Depends on wgmcp_pkg.
//
// Usage: cell costs are pushed on in_cell_cost with push/full, column by
// column, top row first, for a grid of rows_used rows and cols_used columns
// (rows wrap). After the last cell of a grid one transaction appears on
// out_min_path_cost while empty is low and is taken with pop.
// The APB-style port holds rows_used (address 0) and cols_used (address 4);
// any write restarts the grid. The user must write only while the block is
// idle; the block does not enforce this. Throughput: one cell per cycle
// while full is low and no finished grid waits on a pending result. Each
// cell's path cost depends on the one computed before it, so the back
// end's three-way minimum, add and saturate are combinational around the
// last-path register. The result register is loaded when the back end pops
// a grid's last cell; the back end works on each cell while it is queued.
// A stalled receiver holds the result; the next grid streams until its own
// last cell, which waits, and full rises once the two-entry queue fills.
// Reset: rows_used 5, cols_used 6, the grid position returns to its start
// and the queue and result register are emptied.
module wrapped_grid_min_cost_path_top
  import wgmcp_pkg::*;
#(
  parameter int MAX_ROWS = 8,
  parameter int MAX_COLS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Cell input
  input  logic                  push,
  output logic                  full,
  input  logic [COST_W-1:0]     in_cell_cost,
  // Result output
  output logic                  empty,
  input  logic                  pop,
  output logic [PATH_W-1:0]     out_min_path_cost,
  // Configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  logic [ROWS_CFG_W-1:0] rows_used_r;
  logic [COLS_CFG_W-1:0] cols_used_r;
  logic                  cfg_wr;
  logic                  cfg_idx;
  logic [ROW_W-1:0]      rows_m1;
  logic [COL_W-1:0]      cols_m1;
  logic [7:0]            rows_ext;
  logic [10:0]           cols_ext;

  logic      in_fire;
  cell_cmd_t front_cmd;
  cell_cmd_t q_cmd;
  logic      q_valid;
  logic      q_pop;
  logic      res_valid;

  // Configuration port: always ready, one register per word.
  assign pready  = 1'b1;
  assign cfg_idx = paddr[2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_used_r <= ROWS_RESET;
      cols_used_r <= COLS_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ROWS_USED: rows_used_r <= pwdata[ROWS_CFG_W-1:0];
        REG_COLS_USED: cols_used_r <= pwdata[COLS_CFG_W-1:0];
        default:       rows_used_r <= rows_used_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ROWS_USED: prdata = {{(CFG_DATA_W - ROWS_CFG_W){1'b0}}, rows_used_r};
      REG_COLS_USED: prdata = {{(CFG_DATA_W - COLS_CFG_W){1'b0}}, cols_used_r};
      default:       prdata = '0;
    endcase
  end

  // Clamp the configured sizes into range and keep them as last indexes.
  always_comb begin
    rows_ext = {{(8 - ROWS_CFG_W){1'b0}}, rows_used_r};
    cols_ext = {{(11 - COLS_CFG_W){1'b0}}, cols_used_r};
    if (rows_ext == 8'd0) begin
      rows_m1 = '0;
    end else if (rows_ext > 8'(MAX_ROWS)) begin
      rows_m1 = ROW_W'(MAX_ROWS - 1);
    end else begin
      rows_m1 = ROW_W'(rows_ext - 8'd1);
    end
    if (cols_ext == 11'd0) begin
      cols_m1 = '0;
    end else if (cols_ext > 11'(MAX_COLS)) begin
      cols_m1 = COL_W'(MAX_COLS - 1);
    end else begin
      cols_m1 = COL_W'(cols_ext - 11'd1);
    end
  end

  assign in_fire = push && !full;

  wgmcp_front #(
    .ROW_W (ROW_W),
    .COL_W (COL_W)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .restart (cfg_wr),
    .rows_m1 (rows_m1),
    .cols_m1 (cols_m1),
    .in_fire (in_fire),
    .in_cost (in_cell_cost),
    .cmd     (front_cmd)
  );

  wgmcp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (in_fire),
    .wr_data  (front_cmd),
    .full     (full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_data  (q_cmd)
  );

  wgmcp_back #(
    .MAX_ROWS (MAX_ROWS),
    .ROW_W    (ROW_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rows_m1   (rows_m1),
    .cmd_valid (q_valid),
    .cmd       (q_cmd),
    .cmd_pop   (q_pop),
    .out_valid (res_valid),
    .out_cost  (out_min_path_cost),
    .out_pop   (pop && res_valid)
  );

  assign empty = !res_valid;

endmodule
